FILE: rtl/trs_pkg.sv
package trs_pkg;

  localparam int unsigned MaxTasks = 16;
  localparam int unsigned IdW      = $clog2(MaxTasks);
  localparam int unsigned CntW     = $clog2(MaxTasks + 1);

  // fixed field widths
  localparam int unsigned CmdW  = 3;
  localparam int unsigned StsW  = 3;
  localparam int unsigned CfgW  = 5;
  localparam int unsigned InDW  = 8;
  localparam int unsigned OutDW = 16;

  typedef enum logic [CmdW-1:0] {
    CmdStart  = 3'd0,
    CmdCreate = 3'd1,
    CmdKill   = 3'd2,
    CmdSwitch = 3'd3,
    CmdFinish = 3'd4,
    CmdStop   = 3'd5
  } cmd_e;

  typedef enum logic [StsW-1:0] {
    StsOk      = 3'd0,
    StsNotRun  = 3'd1,
    StsFull    = 3'd2,
    StsRefused = 3'd3,
    StsStopped = 3'd4
  } status_e;

  // one request to the link tables per cycle
  typedef struct packed {
    logic           rd_en;
    logic [IdW-1:0] rd_addr;
    logic           next_we;
    logic [IdW-1:0] next_addr;
    logic [IdW-1:0] next_data;
    logic           prev_we;
    logic [IdW-1:0] prev_addr;
    logic [IdW-1:0] prev_data;
  } link_req_t;

endpackage

FILE: rtl/trs_link_mem.sv
module trs_link_mem (
  input  logic                       clk_i,
  input  trs_pkg::link_req_t         req_i,
  output logic [trs_pkg::IdW-1:0]    next_o,
  output logic [trs_pkg::IdW-1:0]    prev_o
);

  logic [trs_pkg::IdW-1:0] next_mem [trs_pkg::MaxTasks];
  logic [trs_pkg::IdW-1:0] prev_mem [trs_pkg::MaxTasks];
  logic [trs_pkg::IdW-1:0] next_q;
  logic [trs_pkg::IdW-1:0] prev_q;

  always_ff @(posedge clk_i) begin
    if (req_i.next_we) begin
      next_mem[req_i.next_addr] <= req_i.next_data;
    end
    if (req_i.prev_we) begin
      prev_mem[req_i.prev_addr] <= req_i.prev_data;
    end
  end

  // registered read, held while no read is requested
  always_ff @(posedge clk_i) begin
    if (req_i.rd_en) begin
      next_q <= next_mem[req_i.rd_addr];
      prev_q <= prev_mem[req_i.rd_addr];
    end
  end

  assign next_o = next_q;
  assign prev_o = prev_q;

endmodule

FILE: rtl/task_ring_scheduler.sv
// channel   dir  width  contents (lsb first)
// s_axis    in   8      command[2:0], task_id[6:3], zero pad
// m_axis    out  16     status[2:0], new_id[6:3], current_id[10:7], task_total[15:11]
// cfg       in   5      slots_in_use
//
// One command at a time; s_axis_tready is high only while the sequencer idles.
// Steps from accept to result: start/stop/not running go from exec to resp; switch reads
// the links and advances; kill checks, reads and unlinks (refused goes to resp); finish
// advances, then retires the old task (main task stops at once); create scans for a free slot.
// A result waiting on m_axis does not block the next accept; the block stalls
// only at its final step until the output frees. Reset clears the slot valid bits.
module task_ring_scheduler (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // slave stream: command[2:0], task_id[6:3]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [trs_pkg::InDW-1:0]      s_axis_tdata,
  // master stream: status, new_id, current_id, task_total
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [trs_pkg::OutDW-1:0]     m_axis_tdata,
  // config write: slots_in_use
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [trs_pkg::CfgW-1:0]      cfg_data_i
);

  typedef enum logic [10:0] {
    StIdle    = 11'b000_0000_0001,
    StExec    = 11'b000_0000_0010,
    StScan    = 11'b000_0000_0100,
    StRdLink  = 11'b000_0000_1000,
    StCrW1    = 11'b000_0001_0000,
    StCrW2    = 11'b000_0010_0000,
    StAdvance = 11'b000_0100_0000,
    StKillChk = 11'b000_1000_0000,
    StRdKill  = 11'b001_0000_0000,
    StKillWr  = 11'b010_0000_0000,
    StResp    = 11'b100_0000_0000
  } state_e;

  state_e                         state_q, state_d;
  trs_pkg::cmd_e                  cmd_q, cmd_d;
  logic [trs_pkg::IdW-1:0]        tgt_q, tgt_d;
  logic [trs_pkg::CntW-1:0]       scan_q, scan_d;
  logic [trs_pkg::MaxTasks-1:0]   active_q, active_d;
  logic [trs_pkg::IdW-1:0]        cur_q, cur_d;
  logic [trs_pkg::CntW-1:0]       total_q, total_d;
  logic                           running_q, running_d;
  trs_pkg::status_e               status_q, status_d;
  logic [trs_pkg::IdW-1:0]        new_id_q, new_id_d;
  logic [trs_pkg::CfgW-1:0]       slots_q;
  logic                           m_valid_q;
  logic [trs_pkg::OutDW-1:0]      m_data_q;

  logic [trs_pkg::CntW-1:0]       n_eff;
  logic                           out_free;
  logic                           kill_bad;
  trs_pkg::link_req_t             lreq;
  logic [trs_pkg::IdW-1:0]        next_rd;
  logic [trs_pkg::IdW-1:0]        prev_rd;

  // effective table size, clamped to 1..MaxTasks
  always_comb begin
    if (slots_q == '0) begin
      n_eff = trs_pkg::CntW'(1);
    end else if (trs_pkg::CntW'(slots_q) > trs_pkg::CntW'(trs_pkg::MaxTasks)) begin
      n_eff = trs_pkg::CntW'(trs_pkg::MaxTasks);
    end else begin
      n_eff = trs_pkg::CntW'(slots_q);
    end
  end

  assign out_free = !m_valid_q || m_axis_tready;

  assign kill_bad = (tgt_q == '0) || (trs_pkg::CntW'(tgt_q) >= n_eff) ||
                    (tgt_q == cur_q) || !active_q[tgt_q];

  trs_link_mem u_links (
    .clk_i  (clk_i),
    .req_i  (lreq),
    .next_o (next_rd),
    .prev_o (prev_rd)
  );

  always_comb begin
    state_d   = state_q;
    cmd_d     = cmd_q;
    tgt_d     = tgt_q;
    scan_d    = scan_q;
    active_d  = active_q;
    cur_d     = cur_q;
    total_d   = total_q;
    running_d = running_q;
    status_d  = status_q;
    new_id_d  = new_id_q;
    lreq      = '0;
    lreq.rd_addr = (state_q == StRdKill) ? tgt_q : cur_q;
    lreq.rd_en   = (state_q == StRdKill) || (state_q == StRdLink);

    case (state_q)
      StIdle: begin
        if (s_axis_tvalid) begin
          cmd_d   = trs_pkg::cmd_e'(s_axis_tdata[trs_pkg::CmdW-1:0]);
          tgt_d   = s_axis_tdata[trs_pkg::CmdW +: trs_pkg::IdW];
          state_d = StExec;
        end
      end
      StExec: begin
        status_d = trs_pkg::StsOk;
        new_id_d = '0;
        state_d  = StResp;
        if (cmd_q == trs_pkg::CmdStart) begin
          active_d       = trs_pkg::MaxTasks'(1);
          cur_d          = '0;
          total_d        = trs_pkg::CntW'(1);
          running_d      = 1'b1;
          lreq.next_we   = 1'b1;
          lreq.prev_we   = 1'b1;
        end else if (!running_q) begin
          status_d = trs_pkg::StsNotRun;
        end else begin
          case (cmd_q)
            trs_pkg::CmdCreate: begin
              scan_d  = trs_pkg::CntW'(1);
              state_d = StScan;
            end
            trs_pkg::CmdKill: begin
              state_d = StKillChk;
            end
            trs_pkg::CmdSwitch: begin
              state_d = StRdLink;
            end
            trs_pkg::CmdFinish: begin
              if (cur_q == '0) begin
                active_d  = '0;
                total_d   = '0;
                running_d = 1'b0;
                status_d  = trs_pkg::StsStopped;
              end else begin
                tgt_d   = cur_q;
                state_d = StRdLink;
              end
            end
            trs_pkg::CmdStop: begin
              active_d  = '0;
              cur_d     = '0;
              total_d   = '0;
              running_d = 1'b0;
              status_d  = trs_pkg::StsStopped;
            end
            default: begin
              status_d = trs_pkg::StsRefused;
            end
          endcase
        end
      end
      // one slot per cycle: lowest free slot from 1 upward
      StScan: begin
        if (scan_q >= n_eff) begin
          status_d = trs_pkg::StsFull;
          state_d  = StResp;
        end else if (active_q[scan_q[trs_pkg::IdW-1:0]]) begin
          scan_d = scan_q + trs_pkg::CntW'(1);
        end else begin
          state_d = StRdLink;
        end
      end
      StRdLink: begin
        state_d = (cmd_q == trs_pkg::CmdCreate) ? StCrW1 : StAdvance;
      end
      // new slot points at current and its old predecessor
      StCrW1: begin
        lreq.next_we   = 1'b1;
        lreq.next_addr = scan_q[trs_pkg::IdW-1:0];
        lreq.next_data = cur_q;
        lreq.prev_we   = 1'b1;
        lreq.prev_addr = scan_q[trs_pkg::IdW-1:0];
        lreq.prev_data = prev_rd;
        state_d        = StCrW2;
      end
      StCrW2: begin
        lreq.next_we   = 1'b1;
        lreq.next_addr = prev_rd;
        lreq.next_data = scan_q[trs_pkg::IdW-1:0];
        lreq.prev_we   = 1'b1;
        lreq.prev_addr = cur_q;
        lreq.prev_data = scan_q[trs_pkg::IdW-1:0];
        active_d[scan_q[trs_pkg::IdW-1:0]] = 1'b1;
        total_d  = total_q + trs_pkg::CntW'(1);
        new_id_d = scan_q[trs_pkg::IdW-1:0];
        state_d  = StResp;
      end
      StAdvance: begin
        cur_d   = next_rd;
        state_d = (cmd_q == trs_pkg::CmdFinish) ? StKillChk : StResp;
      end
      StKillChk: begin
        if (kill_bad) begin
          if (cmd_q == trs_pkg::CmdKill) begin
            status_d = trs_pkg::StsRefused;
          end
          state_d = StResp;
        end else begin
          state_d = StRdKill;
        end
      end
      StRdKill: begin
        state_d = StKillWr;
      end
      // unlink: prev -> next and next -> prev
      StKillWr: begin
        lreq.next_we   = 1'b1;
        lreq.next_addr = prev_rd;
        lreq.next_data = next_rd;
        lreq.prev_we   = 1'b1;
        lreq.prev_addr = next_rd;
        lreq.prev_data = prev_rd;
        active_d[tgt_q] = 1'b0;
        total_d  = total_q - trs_pkg::CntW'(1);
        state_d  = StResp;
      end
      StResp: begin
        if (out_free) begin
          state_d = StIdle;
        end
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= StIdle;
      active_q  <= '0;
      cur_q     <= '0;
      total_q   <= '0;
      running_q <= 1'b0;
      slots_q   <= trs_pkg::CfgW'(trs_pkg::MaxTasks);
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      active_q  <= active_d;
      cur_q     <= cur_d;
      total_q   <= total_d;
      running_q <= running_d;
      if (cfg_valid_i) begin
        slots_q <= cfg_data_i;
      end
      if (state_q == StResp && out_free) begin
        m_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        m_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q    <= cmd_d;
    tgt_q    <= tgt_d;
    scan_q   <= scan_d;
    status_q <= status_d;
    new_id_q <= new_id_d;
    if (state_q == StResp && out_free) begin
      m_data_q <= {total_q, (running_q ? cur_q : trs_pkg::IdW'(0)), new_id_q, status_q};
    end
  end

  assign s_axis_tready = (state_q == StIdle);
  assign m_axis_tvalid = m_valid_q;
  assign m_axis_tdata  = m_data_q;
  assign cfg_ready_o   = 1'b1;

  // task count tracks the valid bits
  a_total_matches : assert property (@(posedge clk_i) disable iff (!rst_ni)
    $countones(active_q) == int'(total_q))
    else $error("task total out of step with slot valid bits");

  // main task is in the ring whenever running
  a_main_active : assert property (@(posedge clk_i) disable iff (!rst_ni)
    running_q |-> active_q[0])
    else $error("running without main task");

  // stopped scheduler holds no slots
  a_stopped_empty : assert property (@(posedge clk_i) disable iff (!rst_ni)
    !running_q |-> (active_q == '0 && total_q == '0))
    else $error("slots left active while stopped");

  // one command at a time
  a_busy_after_accept : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s_axis_tvalid && s_axis_tready) |=> !s_axis_tready)
    else $error("accepted a beat while busy");

endmodule
